// ----- hdl/ms_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ms_pkg;

  localparam int DATA_W = 32;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_RUN_START,
    ST_MERGE,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_t;

  // Write strobes issued by the sequencer to the two stores.
  typedef struct packed {
    logic a_we;
    logic b_we;
  } mem_ctl_t;

endpackage

`default_nettype wire

// ----- hdl/ms_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr_a,
  output logic      [WIDTH-1:0] rdata_a,
  input  wire logic [AW-1:0]    raddr_b,
  output logic      [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Registered reads on both ports; write lands on the single write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

// ----- hdl/merge_sorter_core.sv -----
// Operation: the block is loaded into store A, then merge passes run; each opens every
//   run pair in turn, writes one merged element per cycle, and ends by swapping the stores.
// Emission alternates a read state and a load state per element; a stalled result holds
//   emission, and a new block is loaded only after the last element has gone out.
// Reset: synchronous, active high; clears the sequencer, fill count, overflow flag
//   and result valid. Store contents are left as they are.
`timescale 1ns / 1ps
`default_nettype none

module merge_sorter_core
  import ms_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  // load channel
  input  wire logic                     load_valid,
  output logic                          load_stall,
  input  wire logic signed [DATA_W-1:0] value,
  input  wire logic                     last,
  // result channel
  output logic                          res_valid,
  input  wire logic                     res_stall,
  output logic signed [DATA_W-1:0]      sorted_value,
  output logic                          final_res,
  output logic                          overflow
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);   // fill count, holds DEPTH itself
  localparam int WW = AW + 2;              // run pointers, room for lo + 2*width

  state_t state, state_next;

  // Fill count doubles as block length n during the sort and emission.
  logic [CW-1:0] cnt;
  logic          ovf;

  // Merge sequencer registers.
  logic [WW-1:0] width, lo, mid, hi, lptr, rptr, wptr, k;
  logic          src;    // 0: store A is the source, 1: store B is the source

  // Store ports.
  mem_ctl_t                   ctl;
  logic        [AW-1:0]       rd0_addr, rd1_addr, a_waddr;
  logic        [DATA_W-1:0]   a_wdata;
  logic        [DATA_W-1:0]   a_rd0, a_rd1, b_rd0, b_rd1;

  // Datapath terms.
  logic                       load_acc;
  logic        [WW-1:0]       n_w, sum_w, sum_2w, mid_c, hi_c;
  logic signed [DATA_W-1:0]   dl, dr, mwdata;
  logic                       l_ok, r_ok, take_left, run_end;
  logic        [WW-1:0]       l_next, r_next;

  assign load_acc = load_valid && !load_stall;
  assign n_w      = {{(WW-CW){1'b0}}, cnt};

  // Bounds of the next run pair, clipped to the block length.
  assign sum_w  = lo + width;
  assign sum_2w = lo + (width << 1);
  assign mid_c  = (sum_w  < n_w) ? sum_w  : n_w;
  assign hi_c   = (sum_2w < n_w) ? sum_2w : n_w;

  // Merge step: heads of both runs arrive from the source store each cycle.
  assign dl        = src ? b_rd0 : a_rd0;
  assign dr        = src ? b_rd1 : a_rd1;
  assign l_ok      = lptr < mid;
  assign r_ok      = rptr < hi;
  assign take_left = l_ok && (!r_ok || (dl <= dr));   // left wins ties: stable
  assign mwdata    = take_left ? dl : dr;
  assign l_next    = lptr + {{(WW-1){1'b0}}, take_left};
  assign r_next    = rptr + {{(WW-1){1'b0}}, !take_left};
  assign run_end   = (wptr + WW'(1)) == hi;

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: begin
        if (load_acc && last) state_next = ST_RUN_START;
      end
      ST_RUN_START: begin
        if (width >= n_w) state_next = ST_EMIT_RD;
        else if (lo < n_w) state_next = ST_MERGE;
      end
      ST_MERGE: begin
        if (run_end) state_next = ST_RUN_START;
      end
      ST_EMIT_RD: begin
        if (!res_valid || !res_stall) state_next = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        if ((k + WW'(1)) == n_w) state_next = ST_LOAD;
        else state_next = ST_EMIT_RD;
      end
      default: state_next = ST_LOAD;
    endcase
  end

  // Store control: addresses and write strobes per state.
  always_comb begin
    ctl        = '0;
    load_stall = 1'b1;
    rd0_addr   = lo[AW-1:0];
    rd1_addr   = mid_c[AW-1:0];
    a_waddr    = wptr[AW-1:0];
    a_wdata    = mwdata;
    unique case (state)
      ST_LOAD: begin
        load_stall  = 1'b0;
        ctl.a_we    = load_acc && (cnt < CW'(DEPTH));
        a_waddr     = cnt[AW-1:0];
        a_wdata     = value;
      end
      ST_RUN_START: begin
        // prime both run heads
        rd0_addr = lo[AW-1:0];
        rd1_addr = mid_c[AW-1:0];
      end
      ST_MERGE: begin
        rd0_addr = l_next[AW-1:0];
        rd1_addr = r_next[AW-1:0];
        ctl.a_we = src;
        ctl.b_we = !src;
      end
      ST_EMIT_RD: begin
        rd0_addr = k[AW-1:0];
      end
      ST_EMIT_LD: begin
        rd0_addr = k[AW-1:0];
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

  // Store A takes the load stream; merge passes alternate stores, the first writing store B.
  ms_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_store_a (
    .clk     (clk),
    .we      (ctl.a_we),
    .waddr   (a_waddr),
    .wdata   (a_wdata),
    .raddr_a (rd0_addr),
    .rdata_a (a_rd0),
    .raddr_b (rd1_addr),
    .rdata_b (a_rd1)
  );

  ms_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_store_b (
    .clk     (clk),
    .we      (ctl.b_we),
    .waddr   (wptr[AW-1:0]),
    .wdata   (mwdata),
    .raddr_a (rd0_addr),
    .rdata_a (b_rd0),
    .raddr_b (rd1_addr),
    .rdata_b (b_rd1)
  );

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      cnt       <= '0;
      ovf       <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      // drop the request once taken downstream
      if (res_valid && !res_stall) res_valid <= 1'b0;
      unique case (state)
        ST_LOAD: begin
          if (load_acc) begin
            if (cnt < CW'(DEPTH)) cnt <= cnt + CW'(1);
            else ovf <= 1'b1;   // store full: drop the request, flag the block
          end
        end
        ST_EMIT_LD: begin
          res_valid <= 1'b1;
          if ((k + WW'(1)) == n_w) begin
            cnt <= '0;
            ovf <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Sequencer and result payload registers.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_LOAD: begin
        width <= WW'(1);
        lo    <= '0;
        src   <= 1'b0;
        k     <= '0;
      end
      ST_RUN_START: begin
        if (width < n_w) begin
          if (lo < n_w) begin
            // open the next run pair; a lone tail run is simply copied
            mid  <= mid_c;
            hi   <= hi_c;
            lptr <= lo;
            rptr <= mid_c;
            wptr <= lo;
          end else begin
            // pass done: double the run width and swap the stores
            width <= width << 1;
            lo    <= '0;
            src   <= !src;
          end
        end
      end
      ST_MERGE: begin
        lptr <= l_next;
        rptr <= r_next;
        wptr <= wptr + WW'(1);
        if (run_end) lo <= hi;
      end
      ST_EMIT_LD: begin
        sorted_value <= src ? b_rd0 : a_rd0;
        final_res    <= (k + WW'(1)) == n_w;
        overflow     <= ovf;
        k            <= k + WW'(1);
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire
